/* rtl/core/cscc_pkg.sv */
`default_nettype none

package cscc_pkg;

    localparam int unsigned CRC_W       = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned ABITS_W     = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;
    localparam logic [ABITS_W-1:0] ADDR_BITS_MAX = 3'd5;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_REG_ADDR    = 3'd0,
        CFG_CMD_REG_ADDR    = 3'd1,
        CFG_FRAME_DATA_ADDR = 3'd2,
        CFG_RESET_CRC_CODE  = 3'd3,
        CFG_ADDRESS_BITS    = 3'd4,
        CFG_AUTO_CRC_ENABLE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0]  crc_reg_addr;
        logic [ADDR_W-1:0]  cmd_reg_addr;
        logic [ADDR_W-1:0]  frame_data_addr;
        logic [WORD_W-1:0]  reset_crc_code;
        logic [ABITS_W-1:0] address_bits;
        logic               auto_crc_enable;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] reg_address;
        logic [WORD_W-1:0] payload_word;
        logic              first_word;
        logic              last_word;
    } t_in_word;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             crc_kind;
    } t_crc_word;

    // one serial crc step, msb-style
    function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                                  input logic din);
        logic top;
        top = crc[CRC_W-1] ^ din;
        return {crc[CRC_W-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
    endfunction

    // payload word folded lsb first, unrolls to an xor network
    function automatic logic [CRC_W-1:0] crc_word(input logic [CRC_W-1:0] crc,
                                                   input logic [WORD_W-1:0] w);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = 0; i < WORD_W; i++) begin
            c = crc_bit(c, w[i]);
        end
        return c;
    endfunction

    // low nab address bits folded lsb first
    function automatic logic [CRC_W-1:0] crc_addr(input logic [CRC_W-1:0] crc,
                                                   input logic [ADDR_W-1:0] a,
                                                   input logic [ABITS_W-1:0] nab);
        logic [CRC_W-1:0] c;
        c = crc;
        for (int i = 0; i < ADDR_W; i++) begin
            if (ABITS_W'(i) < nab) begin
                c = crc_bit(c, a[i]);
            end
        end
        return c;
    endfunction

    function automatic logic [CRC_W-1:0] bit_rev(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cscc_stream_if.sv */
`default_nettype none

interface cscc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/config_stream_crc16_check_top.sv */
// path: a taken word is held in the input register, its crc result then in the result register
// throughput: one word per cycle unless a held result stalls it; the crc loop is a combinational 37-bit xor network
// ready drops only while both the input register and the result register are held
// reset (sync, active low): crc cleared, skip flag cleared, valid flags cleared, config regs back to defaults
// no clearing pass and no memory; words are accepted in the first cycle after reset
`default_nettype none

module config_stream_crc16_check_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [cscc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [cscc_pkg::WORD_W-1:0]       i_cfg_data,
    cscc_stream_if.sink                      i_word,
    cscc_stream_if.source                    o_crc
);

    cscc_pkg::t_cfg cfg;

    cscc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register stage
    logic               r_in_valid;
    cscc_pkg::t_in_word r_in;

    // crc state
    logic [cscc_pkg::CRC_W-1:0] r_crc;
    logic [cscc_pkg::CRC_W-1:0] n_crc;
    logic                       r_skip;
    logic                       n_skip;

    // result register
    logic                cscc_emit;
    logic                r_out_valid;
    cscc_pkg::t_crc_word r_out;
    cscc_pkg::t_crc_word n_out;

    logic move;
    logic in_take;

    // the word in the input register is processed when the result register is free or being read out
    assign move    = r_in_valid && (!r_out_valid || o_crc.ready);
    assign in_take = i_word.valid && i_word.ready;
    assign i_word.ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_word.data;
        end
    end

    // per-word crc work, all combinational
    logic [cscc_pkg::CRC_W-1:0]   crc_start;
    logic [cscc_pkg::CRC_W-1:0]   crc_fold;
    logic [cscc_pkg::ABITS_W-1:0] nab;
    logic                         skip_now;

    always_comb begin
        crc_start = r_crc;
        skip_now  = r_skip;
        cscc_emit = 1'b0;
        n_out.crc_value = cscc_pkg::bit_rev(r_crc);
        n_out.crc_kind  = 1'b0;
        nab = (cfg.address_bits > cscc_pkg::ADDR_BITS_MAX) ?
              cscc_pkg::ADDR_BITS_MAX : cfg.address_bits;

        // packet kind is settled on the first word; crc register wins over command
        if (r_in.first_word) begin
            skip_now = 1'b0;
            if (r_in.reg_address == cfg.crc_reg_addr) begin
                cscc_emit = 1'b1;
                crc_start = '0;
                skip_now  = 1'b1;
            end else if (r_in.reg_address == cfg.cmd_reg_addr &&
                         r_in.payload_word == cfg.reset_crc_code) begin
                crc_start = '0;
                skip_now  = 1'b1;
            end
        end

        // 32 word bits then the low address bits
        crc_fold = cscc_pkg::crc_addr(cscc_pkg::crc_word(crc_start, r_in.payload_word),
                                      r_in.reg_address, nab);
        n_crc = crc_start;

        if (!skip_now) begin
            n_crc = crc_fold;
            // auto crc at the end of a frame data packet
            if (r_in.last_word && cfg.auto_crc_enable &&
                r_in.reg_address == cfg.frame_data_addr) begin
                cscc_emit = 1'b1;
                n_out.crc_value = cscc_pkg::bit_rev(crc_fold);
                n_out.crc_kind  = 1'b1;
                n_crc = '0;
            end
        end

        n_skip = skip_now && !r_in.last_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_skip <= 1'b0;
        end else if (move) begin
            r_crc  <= n_crc;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= cscc_emit;
        end else if (o_crc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && cscc_emit) begin
            r_out <= n_out;
        end
    end

    assign o_crc.valid = r_out_valid;
    assign o_crc.data  = r_out;

    // every emitted crc restarts the remainder
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && cscc_emit) |=> (r_crc == '0))
        else $error("crc not cleared after result");

    // a packet's last word always closes the skip window
    a_last_clears_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in.last_word) |=> !r_skip)
        else $error("skip flag survived last word");

    // a held result blocks processing of the next word
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_crc.ready) |-> !move)
        else $error("result register overrun");

    // crc state only moves when a word is processed
    a_crc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_crc) && $stable(r_skip))
        else $error("crc state changed without a word");

endmodule

`default_nettype wire

/* rtl/core/cscc_cfg_regs.sv */
`default_nettype none

module cscc_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [cscc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [cscc_pkg::WORD_W-1:0]       i_cfg_data,
    output cscc_pkg::t_cfg                   o_cfg
);

    cscc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_reg_addr    <= 5'd0;
            r_cfg.cmd_reg_addr    <= 5'd4;
            r_cfg.frame_data_addr <= 5'd2;
            r_cfg.reset_crc_code  <= 32'd7;
            r_cfg.address_bits    <= 3'd5;
            r_cfg.auto_crc_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (cscc_pkg::t_cfg_idx'(i_cfg_idx))
                cscc_pkg::CFG_CRC_REG_ADDR: begin
                    r_cfg.crc_reg_addr <= i_cfg_data[cscc_pkg::ADDR_W-1:0];
                end
                cscc_pkg::CFG_CMD_REG_ADDR: begin
                    r_cfg.cmd_reg_addr <= i_cfg_data[cscc_pkg::ADDR_W-1:0];
                end
                cscc_pkg::CFG_FRAME_DATA_ADDR: begin
                    r_cfg.frame_data_addr <= i_cfg_data[cscc_pkg::ADDR_W-1:0];
                end
                cscc_pkg::CFG_RESET_CRC_CODE: begin
                    r_cfg.reset_crc_code <= i_cfg_data;
                end
                cscc_pkg::CFG_ADDRESS_BITS: begin
                    r_cfg.address_bits <= i_cfg_data[cscc_pkg::ABITS_W-1:0];
                end
                cscc_pkg::CFG_AUTO_CRC_ENABLE: begin
                    r_cfg.auto_crc_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // package items used here, by scoped name
    localparam int unsigned CRC_W   = cscc_pkg::CRC_W;
    localparam int unsigned WORD_W  = cscc_pkg::WORD_W;
    localparam int unsigned ADDR_W  = cscc_pkg::ADDR_W;
    localparam int unsigned ABITS_W = cscc_pkg::ABITS_W;
    localparam logic [CRC_W-1:0]   CRC_POLY      = cscc_pkg::CRC_POLY;
    localparam logic [ABITS_W-1:0] ADDR_BITS_MAX = cscc_pkg::ADDR_BITS_MAX;

    typedef cscc_pkg::t_cfg      t_cfg;
    typedef cscc_pkg::t_cfg_idx  t_cfg_idx;
    typedef cscc_pkg::t_in_word  t_in_word;
    typedef cscc_pkg::t_crc_word t_crc_word;

    // meaning of the crc_kind bit of a result word
    localparam logic KIND_CRC_REG = 1'b0;
    localparam logic KIND_AUTO    = 1'b1;

    // drain wait covering the input and result registers of the block, with margin
    localparam int DRAIN_CYCLES = 8;
    // about 900 words, each at worst delayed by a driver gap and a receiver stall,
    // plus the pauses around each setting change, taken many times over
    localparam int CYCLE_LIMIT  = 200000;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    initial forever #5 i_clk = ~i_clk;

    // configuration port, driven only by the main sequence
    logic               cfg_we   = 1'b0;
    t_cfg_idx           cfg_idx  = cscc_pkg::CFG_CRC_REG_ADDR;
    logic [WORD_W-1:0]  cfg_data = '0;

    // stream channels, every input known from time zero
    cscc_stream_if #(.T(t_in_word))  word_if ();
    cscc_stream_if #(.T(t_crc_word)) crc_if ();

    logic      word_valid = 1'b0;
    t_in_word  word_data  = '0;
    logic      crc_ready  = 1'b0;

    assign word_if.valid = word_valid;
    assign word_if.data  = word_data;
    assign crc_if.ready  = crc_ready;

    config_stream_crc16_check_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_word     (word_if),
        .o_crc      (crc_if)
    );

    // words waiting to be sent and crc words waiting to arrive
    t_in_word  pending_words[$];
    t_crc_word crc_expected[$];

    // shadow of the block: register settings, crc remainder, skip flag
    t_cfg              cfg_shadow = '{crc_reg_addr: 5'd0, cmd_reg_addr: 5'd4,
                                      frame_data_addr: 5'd2, reset_crc_code: 32'd7,
                                      address_bits: 3'd5, auto_crc_enable: 1'b1};
    logic [CRC_W-1:0]  crc_rem   = '0;
    logic              skip_rest = 1'b0;

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    // idling is switched off for the final phase and during quiet stretches
    logic calm           = 1'b0;
    int   quiet_left     = 0;
    int   word_gap       = 0;
    int   crc_stall      = 0;

    // ------------------------------------------------------------------
    // crc prediction
    // ------------------------------------------------------------------

    // shift one data bit into the remainder, top bit first out
    function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] c,
                                                   input logic b);
        logic [CRC_W-1:0] shifted;
        shifted = c << 1;
        return (c[CRC_W-1] != b) ? (shifted ^ CRC_POLY) : shifted;
    endfunction

    // the reported crc is the remainder mirrored end for end
    function automatic logic [CRC_W-1:0] reflect16(input logic [CRC_W-1:0] c);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[CRC_W-1-i] = c[i];
        end
        return r;
    endfunction

    // advance the shadow by one accepted word, queue any crc word it causes
    task automatic predict_crc(input t_in_word w);
        t_crc_word         res;
        logic              skip;
        logic [ABITS_W-1:0] nab;
        skip = skip_rest;
        // the packet kind is only decided on its first word
        if (w.first_word) begin
            skip = 1'b0;
            if (w.reg_address == cfg_shadow.crc_reg_addr) begin
                // crc register write: report and restart, words not folded
                res.crc_value = reflect16(crc_rem);
                res.crc_kind  = KIND_CRC_REG;
                crc_expected = {crc_expected, res};
                crc_rem = '0;
                skip    = 1'b1;
            end else if (w.reg_address == cfg_shadow.cmd_reg_addr &&
                         w.payload_word == cfg_shadow.reset_crc_code) begin
                // reset command: restart only
                crc_rem = '0;
                skip    = 1'b1;
            end
        end
        if (!skip) begin
            // address_bits above the address width folds all five bits
            nab = (cfg_shadow.address_bits > ADDR_BITS_MAX) ? ADDR_BITS_MAX
                                                             : cfg_shadow.address_bits;
            for (int i = 0; i < WORD_W; i++) begin
                crc_rem = crc_shift(crc_rem, w.payload_word[i]);
            end
            for (int i = 0; i < ADDR_W; i++) begin
                if (i < int'(nab)) begin
                    crc_rem = crc_shift(crc_rem, w.reg_address[i]);
                end
            end
            // frame data end: the address of the last word itself decides
            if (w.last_word && cfg_shadow.auto_crc_enable &&
                w.reg_address == cfg_shadow.frame_data_addr) begin
                res.crc_value = reflect16(crc_rem);
                res.crc_kind  = KIND_AUTO;
                crc_expected = {crc_expected, res};
                crc_rem = '0;
            end
        end
        skip_rest = skip && !w.last_word;
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] rand_payload();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data,
                            input logic first, input logic last);
        t_in_word w;
        w.reg_address  = addr;
        w.payload_word = data;
        w.first_word   = first;
        w.last_word    = last;
        pending_words = {pending_words, w};
    endtask

    // well-formed packet: first mark on word 0, last mark on the final word
    task automatic add_packet(input logic [ADDR_W-1:0] addr, input int len,
                              input logic [WORD_W-1:0] head);
        for (int i = 0; i < len; i++) begin
            add_word(addr, (i == 0) ? head : rand_payload(), i == 0, i == len - 1);
        end
    endtask

    // mostly well-formed packets of every kind, some loose noise words
    task automatic add_random_traffic(input int n_words);
        int start;
        int len;
        int pick;
        start = pending_words.size();
        while (pending_words.size() - start < n_words) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (pick < 35) begin
                add_packet(cfg_shadow.frame_data_addr, $urandom_range(1, 6), rand_payload());
            end else if (pick < 50) begin
                add_packet(cfg_shadow.crc_reg_addr, len, rand_payload());
            end else if (pick < 58) begin
                add_packet(cfg_shadow.cmd_reg_addr, $urandom_range(1, 2),
                           cfg_shadow.reset_crc_code);
            end else if (pick < 63) begin
                add_packet(cfg_shadow.cmd_reg_addr, len, rand_payload());
            end else if (pick < 80) begin
                add_packet(ADDR_W'($urandom_range(0, 31)), len, rand_payload());
            end else begin
                add_word(ADDR_W'($urandom_range(0, 31)), rand_payload(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // configuration writes, only while the block is idle
    // ------------------------------------------------------------------

    task automatic write_reg(input t_cfg_idx idx, input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
    endtask

    // unused upper data bits carry junk, the block must ignore them
    task automatic apply_setting(input t_cfg s);
        write_reg(cscc_pkg::CFG_CRC_REG_ADDR,    {27'($urandom), s.crc_reg_addr});
        write_reg(cscc_pkg::CFG_CMD_REG_ADDR,    {27'($urandom), s.cmd_reg_addr});
        write_reg(cscc_pkg::CFG_FRAME_DATA_ADDR, {27'($urandom), s.frame_data_addr});
        write_reg(cscc_pkg::CFG_RESET_CRC_CODE,  s.reset_crc_code);
        write_reg(cscc_pkg::CFG_ADDRESS_BITS,    {29'($urandom), s.address_bits});
        write_reg(cscc_pkg::CFG_AUTO_CRC_ENABLE, {31'($urandom), s.auto_crc_enable});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        cfg_shadow = s;
    endtask

    // all words sent, all crc words back, then let the pipeline settle
    task automatic wait_drained();
        while (pending_words.size() != 0 || word_valid || crc_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input t_cfg s, input int n_words, input logic final_phase);
        wait_drained();
        apply_setting(s);
        calm = final_phase;
        add_random_traffic(n_words);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset settings:
        // crc at 0, command at 4, frame data at 2, reset code 7

        // crc read straight after reset
        add_word(5'd0, 32'h0000_0000, 1'b1, 1'b1);
        // single-word frame data packet
        add_word(5'd2, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // frame data with the address changing inside the packet
        add_word(5'd2, 32'h0000_0000, 1'b1, 1'b0);
        add_word(5'd31, 32'h8000_0001, 1'b0, 1'b0);
        add_word(5'd2, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // plain register packet, folded with no result
        add_word(5'd31, 32'h1234_5678, 1'b1, 1'b0);
        add_word(5'd31, rand_payload(), 1'b0, 1'b1);
        // crc register packet: the second word is skipped
        add_word(5'd0, 32'hDEAD_BEEF, 1'b1, 1'b0);
        add_word(5'd0, 32'h0000_0000, 1'b0, 1'b1);
        // reset command, then read back zero
        add_word(5'd4, 32'd7, 1'b1, 1'b1);
        add_word(5'd0, 32'h0000_0000, 1'b1, 1'b1);
        // command with another value folds; the code in a later word does not reset
        add_word(5'd4, 32'd8, 1'b1, 1'b0);
        add_word(5'd4, 32'd7, 1'b0, 1'b1);
        // reset command packet: later words at crc and frame addresses are skipped
        add_word(5'd4, 32'd7, 1'b1, 1'b0);
        add_word(5'd0, 32'h0000_0000, 1'b0, 1'b0);
        add_word(5'd2, 32'h0000_0001, 1'b0, 1'b1);
        // words with no first mark are folded, the last one at frame data emits
        add_word(5'd17, 32'hAAAA_AAAA, 1'b0, 1'b0);
        add_word(5'd2, 32'h5555_5555, 1'b0, 1'b1);
        // unfinished crc packet cut short by a new first word
        add_word(5'd0, 32'h0000_0000, 1'b1, 1'b0);
        add_word(5'd0, 32'h0000_0001, 1'b1, 1'b1);
        // loose single word, then a read
        add_word(5'd1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_word(5'd0, 32'h0000_0000, 1'b1, 1'b1);

        add_random_traffic(150);

        // low extremes, auto crc off
        run_phase(t_cfg'{crc_reg_addr: 5'd31, cmd_reg_addr: 5'd0, frame_data_addr: 5'd1,
                         reset_crc_code: 32'h0000_0000, address_bits: 3'd0,
                         auto_crc_enable: 1'b0}, 140, 1'b0);
        // all three addresses the same, crc register wins
        run_phase(t_cfg'{crc_reg_addr: 5'd3, cmd_reg_addr: 5'd3, frame_data_addr: 5'd3,
                         reset_crc_code: 32'hFFFF_FFFF, address_bits: 3'd7,
                         auto_crc_enable: 1'b1}, 140, 1'b0);
        // command overlaps frame data, address_bits above five
        run_phase(t_cfg'{crc_reg_addr: 5'd5, cmd_reg_addr: 5'd17, frame_data_addr: 5'd17,
                         reset_crc_code: 32'hA5A5_5A5A, address_bits: 3'd6,
                         auto_crc_enable: 1'b1}, 140, 1'b0);
        run_phase(t_cfg'{crc_reg_addr: 5'd20, cmd_reg_addr: 5'd31, frame_data_addr: 5'd0,
                         reset_crc_code: $urandom, address_bits: 3'd3,
                         auto_crc_enable: 1'b1}, 140, 1'b0);
        // last part without any idling
        run_phase(t_cfg'{crc_reg_addr: 5'd7, cmd_reg_addr: 5'd31, frame_data_addr: 5'd30,
                         reset_crc_code: 32'hFFFF_FFFF, address_bits: 3'd5,
                         auto_crc_enable: 1'b1}, 140, 1'b1);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // idling, driver and monitor
    // ------------------------------------------------------------------

    // now and then a stretch where neither side idles
    always @(posedge i_clk) begin
        if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
        end else if ($urandom_range(0, 63) == 0) begin
            quiet_left <= $urandom_range(30, 120);
        end
    end

    // word driver: a word stays up until taken, gaps only between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_valid <= 1'b0;
            word_gap   <= 0;
        end else if (!word_valid || word_if.ready) begin
            if (word_gap > 0) begin
                word_valid <= 1'b0;
                word_gap   <= word_gap - 1;
            end else if (!calm && quiet_left == 0 && $urandom_range(0, 7) == 0) begin
                // start a gap between words
                word_valid <= 1'b0;
                word_gap   <= $urandom_range(0, 7);
            end else if (pending_words.size() != 0) begin
                word_valid <= 1'b1;
                word_data  <= pending_words.pop_front();
            end else begin
                word_valid <= 1'b0;
            end
        end
    end

    // crc receiver stalls now and then, in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crc_ready <= 1'b0;
            crc_stall <= 0;
        end else if (crc_stall > 0) begin
            crc_ready <= 1'b0;
            crc_stall <= crc_stall - 1;
        end else if (!calm && quiet_left == 0 && $urandom_range(0, 9) == 0) begin
            crc_ready <= 1'b0;
            crc_stall <= $urandom_range(0, 7);
        end else begin
            crc_ready <= 1'b1;
        end
    end

    // predict on every taken word, check every taken crc word against the oldest
    always @(posedge i_clk) begin : crc_monitor
        t_crc_word want;
        t_crc_word got;
        if (i_rst_n) begin
            if (word_valid && word_if.ready) begin
                predict_crc(word_data);
            end
            if (crc_if.valid && crc_ready) begin
                got = crc_if.data;
                if (crc_expected.size() == 0) begin
                    report_mismatch($sformatf("crc word %h kind %0d with none expected",
                                              got.crc_value, got.crc_kind));
                end else begin
                    want = crc_expected.pop_front();
                    if (got.crc_value !== want.crc_value) begin
                        report_mismatch($sformatf("crc_value got %h want %h",
                                                  got.crc_value, want.crc_value));
                    end
                    if (got.crc_kind !== want.crc_kind) begin
                        report_mismatch($sformatf("crc_kind got %0d want %0d",
                                                  got.crc_kind, want.crc_kind));
                    end
                end
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

`default_nettype wire
